// File: hw/rtl/tssc_pkg.sv
// Shared types, format codes and arithmetic helpers for the texture surface size calculator.
package tssc_pkg;

	localparam int DIM_W   = 15;
	localparam int LVL_W   = 5;
	localparam int PITCH_W = 18;
	localparam int PROD_W  = 2 * DIM_W;
	localparam int MIPS_W  = 4;
	localparam int BYTES_W = 32;

	typedef enum logic [2:0] {
		CLS_BLOCK8,
		CLS_BLOCK16,
		CLS_8BPP,
		CLS_16BPP,
		CLS_24BPP,
		CLS_32BPP,
		CLS_64BPP,
		CLS_UNKNOWN
	} fmt_class_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} back_state_t;

	typedef struct packed {
		logic [DIM_W-1:0] surface_width;
		logic [DIM_W-1:0] surface_height;
		logic [LVL_W-1:0] level_count;
		fmt_class_t       format_class;
	} desc_t;

	typedef struct packed {
		logic [BYTES_W-1:0] chain_bytes;
		logic [PITCH_W-1:0] row_pitch;
		logic [DIM_W-1:0]   row_total;
		logic [BYTES_W-1:0] face_bytes;
		logic [MIPS_W-1:0]  full_mips;
		logic               format_error;
	} res_t;

	// Classified descriptor handed from the front end to the back end.
	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [LVL_W-1:0]   levels;
		fmt_class_t         format_class;
		logic               is_block;
		logic [PITCH_W-1:0] row_pitch;
		logic [DIM_W-1:0]   row_total;
		logic [MIPS_W-1:0]  full_mips;
		logic               format_error;
	} job_t;

	// Bytes for n pixels (linear) or n blocks (block formats), low 32 bits.
	function automatic logic [BYTES_W-1:0] scale_bytes(input logic [PROD_W-1:0] n,
		input fmt_class_t cls);
		logic [PROD_W+3:0] wide;
		logic [PROD_W+3:0] r;
		wide = {4'b0000, n};
		case (cls) inside
			CLS_BLOCK8, CLS_64BPP: r = wide << 3;
			CLS_BLOCK16:           r = wide << 4;
			CLS_8BPP:              r = wide;
			CLS_16BPP:             r = wide << 1;
			CLS_24BPP:             r = wide + (wide << 1);
			CLS_32BPP:             r = wide << 2;
			default:               r = '0;
		endcase
		return r[BYTES_W-1:0];
	endfunction

	// Number of 4-pixel blocks covering v, rounded up.
	function automatic logic [DIM_W-1:0] block_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W:0] sum;
		sum = {1'b0, v} + (DIM_W+1)'(3);
		return DIM_W'(sum >> 2);
	endfunction

	function automatic logic [MIPS_W-1:0] bit_length(input logic [DIM_W-1:0] v);
		logic [MIPS_W-1:0] n;
		n = '0;
		for (int i = 0; i < DIM_W; i++) begin
			if (v[i]) n = MIPS_W'(i + 1);
		end
		return n;
	endfunction

endpackage

// File: hw/rtl/texture_surface_size_calc.sv
// Texture surface size calculator: mip chain byte total, top-level pitch, rows and face size.
//
// A descriptor (width, height, level count, format class) is a transfer on desc_valid /
// desc_ready; one result per descriptor is a transfer on res_valid / res_ready.
// The front end classifies the descriptor into a two-entry queue; desc_ready drops only
// while that queue is full. The back end takes one descriptor at a time and spends one
// cycle per mip level on the chain sum, driven by a single 15x15 multiplier stage.
// With L the level count after saturation at MAX_LEVELS (zero for an unknown class),
// a descriptor occupies the back end while it issues its L levels, adds the last product
// and waits for the result register to be free; with L zero it goes straight to loading
// its result.
// The result sits in an output register; while the receiver stalls, the back end holds
// its finished sum and the queue keeps accepting until it is full.
// Reset empties the queue, returns the back end to idle and clears res_valid.
module texture_surface_size_calc #(
	parameter int MAX_LEVELS = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             desc_valid,
	output logic             desc_ready,
	input  tssc_pkg::desc_t  desc,
	output logic             res_valid,
	input  logic             res_ready,
	output tssc_pkg::res_t   res
);
	import tssc_pkg::*;

	job_t front_job;
	job_t queued_job;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic q_push;

	assign desc_ready = !q_full;
	assign q_push     = desc_valid && desc_ready;

	tssc_front #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_front (
		.desc(desc),
		.job (front_job)
	);

	tssc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(front_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_data (queued_job)
	);

	tssc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(!q_empty),
		.job      (queued_job),
		.job_take (q_pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

// File: hw/rtl/tssc_front.sv
// Front end: classifies a descriptor and works out its top-level pitch, rows and mip length.
module tssc_front #(
	parameter int MAX_LEVELS = 31
) (
	input  tssc_pkg::desc_t desc,
	output tssc_pkg::job_t  job
);
	import tssc_pkg::*;

	localparam int LVL_MAX = (1 << LVL_W) - 1;
	localparam int LVL_CAP = (MAX_LEVELS > LVL_MAX) ? LVL_MAX : MAX_LEVELS;

	logic               known;
	logic               blk;
	logic [DIM_W-1:0]   top_w;
	logic [DIM_W-1:0]   biggest;
	logic [BYTES_W-1:0] pitch_full;

	always_comb begin
		known   = desc.format_class != CLS_UNKNOWN;
		blk     = desc.format_class == CLS_BLOCK8 || desc.format_class == CLS_BLOCK16;
		top_w   = blk ? block_dim(desc.surface_width) : desc.surface_width;
		biggest = (desc.surface_width > desc.surface_height) ?
			desc.surface_width : desc.surface_height;
		pitch_full = scale_bytes(PROD_W'(top_w), desc.format_class);

		job.width        = desc.surface_width;
		job.height       = desc.surface_height;
		job.format_class = desc.format_class;
		job.is_block     = blk;
		job.full_mips    = bit_length(biggest);
		job.format_error = !known;
		job.row_pitch    = known ? pitch_full[PITCH_W-1:0] : '0;
		if (!known) begin
			job.row_total = '0;
		end else if (blk) begin
			job.row_total = block_dim(desc.surface_height);
		end else begin
			job.row_total = desc.surface_height;
		end
		// an unknown class sums no levels, so the chain total stays zero
		if (!known) begin
			job.levels = '0;
		end else if (int'(desc.level_count) > LVL_CAP) begin
			job.levels = LVL_W'(LVL_CAP);
		end else begin
			job.levels = desc.level_count;
		end
	end

endmodule

// File: hw/rtl/tssc_queue.sv
// Two-entry queue of classified descriptors between the front and back ends.
module tssc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tssc_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output tssc_pkg::job_t pop_data
);
	import tssc_pkg::*;

	job_t       entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: hw/rtl/tssc_back.sv
// Back end: sums the mip chain one level per cycle and holds the result register.
module tssc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  tssc_pkg::job_t job,
	output logic           job_take,
	output logic           res_valid,
	input  logic           res_ready,
	output tssc_pkg::res_t res
);
	import tssc_pkg::*;

	back_state_t        state_q, state_d;
	logic [LVL_W-1:0]   cnt_q;
	logic [DIM_W-1:0]   lw_q, lh_q;
	fmt_class_t         cls_q;
	logic               blk_q;
	logic [BYTES_W-1:0] chain_q;
	logic [PITCH_W-1:0] pitch_q;
	logic [DIM_W-1:0]   rows_q;
	logic [MIPS_W-1:0]  mips_q;
	logic               err_q;
	logic [PROD_W-1:0]  prod_s1;
	logic               v_s1;
	logic               res_valid_q;
	res_t               res_q;

	logic               issue;
	logic               done;
	logic               res_load;
	logic [DIM_W-1:0]   lw_c, lh_c;
	logic [DIM_W-1:0]   dim_a, dim_b;
	logic [BYTES_W:0]   face_full;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		lw_c      = (lw_q == '0) ? DIM_W'(1) : lw_q;
		lh_c      = (lh_q == '0) ? DIM_W'(1) : lh_q;
		dim_a     = blk_q ? block_dim(lw_c) : lw_c;
		dim_b     = blk_q ? block_dim(lh_c) : lh_c;
		issue     = state_q == ST_RUN && cnt_q != '0;
		done      = state_q == ST_RUN && cnt_q == '0 && !v_s1;
		res_load  = done && (!res_valid_q || res_ready);
		job_take  = state_q == ST_IDLE && job_valid;
		face_full = (BYTES_W+1)'(pitch_q) * (BYTES_W+1)'(rows_q);
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: if (job_take) state_d = ST_RUN;
			ST_RUN:  if (res_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			if (job_take) begin
				cnt_q <= job.levels;
			end else if (issue) begin
				cnt_q <= cnt_q - LVL_W'(1);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			lw_q    <= job.width;
			lh_q    <= job.height;
			cls_q   <= job.format_class;
			blk_q   <= job.is_block;
			pitch_q <= job.row_pitch;
			rows_q  <= job.row_total;
			mips_q  <= job.full_mips;
			err_q   <= job.format_error;
			chain_q <= '0;
		end else begin
			// advance to the next level: clamp to 1, then halve
			if (issue) begin
				lw_q <= lw_c >> 1;
				lh_q <= lh_c >> 1;
			end
			if (v_s1) chain_q <= chain_q + scale_bytes(prod_s1, cls_q);
		end
		if (issue) prod_s1 <= PROD_W'(dim_a) * PROD_W'(dim_b);
		if (res_load) begin
			res_q.chain_bytes  <= chain_q;
			res_q.row_pitch    <= pitch_q;
			res_q.row_total    <= rows_q;
			res_q.face_bytes   <= face_full[BYTES_W-1:0];
			res_q.full_mips    <= mips_q;
			res_q.format_error <= err_q;
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!v_s1 && cnt_q == '0))
		else $error("back end idle with a level still in flight");

	a_hold_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res_valid_q && !res_ready) |=> (state_q == ST_RUN && cnt_q == '0))
		else $error("finished descriptor dropped while result register was full");

	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_RUN && cnt_q == '0 && !v_s1))
		else $error("result loaded before the chain sum completed");

endmodule

// File: test/surface_size_checker.sv
`timescale 1ns / 1ps
// Checker for the texture surface size calculator: predicts each result and compares it.
module surface_size_checker #(
	parameter int MAX_LEVELS = 31
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            desc_valid,
	input  logic            desc_ready,
	input  tssc_pkg::desc_t desc,
	input  logic            res_valid,
	input  logic            res_ready,
	input  tssc_pkg::res_t  res,
	output int              errors,
	output int              pending
);
	import tssc_pkg::*;

	res_t expected_sizes[$];
	int   size_mismatches = 0;

	assign errors = size_mismatches;

	function automatic res_t calc_surface_sizes(input desc_t d);
		res_t       r;
		bit [63:0]  unit;
		bit [63:0]  lw;
		bit [63:0]  lh;
		bit [63:0]  pitch;
		bit [63:0]  rows;
		bit [63:0]  face;
		bit [63:0]  level_size;
		bit [31:0]  chain;
		bit [DIM_W-1:0] biggest;
		int         nlev;
		int         i;
		bit         is_block;
		case (d.format_class)
			CLS_BLOCK8:  unit = 8;
			CLS_BLOCK16: unit = 16;
			CLS_8BPP:    unit = 1;
			CLS_16BPP:   unit = 2;
			CLS_24BPP:   unit = 3;
			CLS_32BPP:   unit = 4;
			CLS_64BPP:   unit = 8;
			default:     unit = 0;
		endcase
		is_block = (d.format_class == CLS_BLOCK8) || (d.format_class == CLS_BLOCK16);
		nlev = d.level_count;
		if (nlev > MAX_LEVELS) nlev = MAX_LEVELS;
		chain = '0;
		pitch = '0;
		rows = '0;
		face = '0;
		if (d.format_class != CLS_UNKNOWN) begin
			lw = d.surface_width;
			lh = d.surface_height;
			for (i = 0; i < nlev; i++) begin
				// clamp each level to 1x1 before sizing and halving
				if (lw == 0) lw = 1;
				if (lh == 0) lh = 1;
				if (is_block) level_size = ((lw + 3) / 4) * ((lh + 3) / 4) * unit;
				else level_size = lw * lh * unit;
				chain += level_size[31:0];
				lw = lw >> 1;
				lh = lh >> 1;
			end
			// top-level face values keep zero dimensions as zero
			if (is_block) begin
				pitch = (d.surface_width == 0) ? 0 : ((64'(d.surface_width) + 3) / 4) * unit;
				rows = (d.surface_height == 0) ? 0 : (64'(d.surface_height) + 3) / 4;
			end else begin
				pitch = 64'(d.surface_width) * unit;
				rows = d.surface_height;
			end
			face = pitch * rows;
		end
		biggest = (d.surface_width > d.surface_height) ? d.surface_width : d.surface_height;
		r.full_mips = '0;
		for (i = 0; i < DIM_W; i++) begin
			if (biggest[i]) r.full_mips = MIPS_W'(i + 1);
		end
		r.chain_bytes = chain;
		r.row_pitch = pitch[PITCH_W-1:0];
		r.row_total = rows[DIM_W-1:0];
		r.face_bytes = face[BYTES_W-1:0];
		r.format_error = (d.format_class == CLS_UNKNOWN);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		if (!arst_n) begin
			expected_sizes.delete();
			pending <= 0;
		end else begin
			// retire the result first; a descriptor cannot produce one in its own cycle
			if (res_valid && res_ready) begin
				if (expected_sizes.size() == 0) begin
					size_mismatches++;
					if (size_mismatches <= 10)
						$display("%0t: result transfer with none expected: chain=%0h pitch=%0h",
							$realtime, res.chain_bytes, res.row_pitch);
				end else begin
					exp_r = expected_sizes.pop_front();
					if ((res.chain_bytes !== exp_r.chain_bytes) ||
						(res.row_pitch !== exp_r.row_pitch) ||
						(res.row_total !== exp_r.row_total) ||
						(res.face_bytes !== exp_r.face_bytes) ||
						(res.full_mips !== exp_r.full_mips) ||
						(res.format_error !== exp_r.format_error)) begin
						size_mismatches++;
						if (size_mismatches <= 10) begin
							$display("%0t: exp chain=%0h pitch=%0h rows=%0h face=%0h",
								$realtime, exp_r.chain_bytes, exp_r.row_pitch,
								exp_r.row_total, exp_r.face_bytes);
							$display("%0t: exp mips=%0d err=%0b",
								$realtime, exp_r.full_mips, exp_r.format_error);
							$display("%0t: got chain=%0h pitch=%0h rows=%0h face=%0h",
								$realtime, res.chain_bytes, res.row_pitch,
								res.row_total, res.face_bytes);
							$display("%0t: got mips=%0d err=%0b",
								$realtime, res.full_mips, res.format_error);
						end
					end
				end
			end
			if (desc_valid && desc_ready)
				expected_sizes.push_back(calc_surface_sizes(desc));
			pending <= expected_sizes.size();
		end
	end

endmodule

// File: test/tb_texture_surface_size_calc.sv
`timescale 1ns / 1ps
// Testbench top for the texture surface size calculator: clock, reset, stimulus and verdict.
module tb_texture_surface_size_calc;
	import tssc_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 560;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  desc_valid;
	logic  desc_ready;
	desc_t desc;
	logic  res_valid;
	logic  res_ready;
	res_t  res;
	int    errors;
	int    pending;
	int    quiet_cycles = 0;
	int    tx_idle_pct;
	int    rx_idle_pct;
	int    hold_requests;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	texture_surface_size_calc #(
		.MAX_LEVELS(31)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.desc_valid(desc_valid),
		.desc_ready(desc_ready),
		.desc(desc),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	surface_size_checker #(
		.MAX_LEVELS(31)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.desc_valid(desc_valid),
		.desc_ready(desc_ready),
		.desc(desc),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.errors(errors),
		.pending(pending)
	);

	// End the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (desc_valid && desc_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		int seen_holds;
		int k;
		seen_holds = 0;
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != seen_holds) begin
				seen_holds = hold_requests;
				res_ready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
			end else begin
				res_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic desc_t make_desc(input int w, input int h, input int lvl,
		input fmt_class_t cls);
		desc_t d;
		d.surface_width = DIM_W'(w);
		d.surface_height = DIM_W'(h);
		d.level_count = LVL_W'(lvl);
		d.format_class = cls;
		return d;
	endfunction

	function automatic desc_t random_desc();
		int    pick;
		int    w;
		int    h;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1: begin
				w = $urandom_range(0, 32767);
				h = $urandom_range(0, 32767);
			end
			2, 3, 4: begin
				w = $urandom_range(0, 40);
				h = $urandom_range(0, 40);
			end
			5, 6, 7: begin
				w = $urandom_range(0, 16384);
				h = $urandom_range(0, 16384);
			end
			default: begin
				// powers of two and their neighbors
				w = (1 << $urandom_range(0, 14)) + $urandom_range(0, 2) - 1;
				h = (1 << $urandom_range(0, 14)) + $urandom_range(0, 2) - 1;
			end
		endcase
		return make_desc(w, h, $urandom_range(0, 31), fmt_class_t'(3'($urandom_range(0, 7))));
	endfunction

	// Offer one descriptor, idling first at random; return once it is transferred.
	task automatic offer_desc(input desc_t d);
		while ($urandom_range(99) < tx_idle_pct) begin
			desc_valid <= 1'b0;
			@(posedge clk);
		end
		desc_valid <= 1'b1;
		desc <= d;
		@(posedge clk);
		while (!desc_ready) @(posedge clk);
	endtask

	initial begin
		int c;
		arst_n = 1'b0;
		desc_valid = 1'b0;
		desc = '0;
		tx_idle_pct = 35;
		rx_idle_pct = 88;
		hold_requests = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every class at the nominal maximum size and full chain
		for (c = 0; c < 8; c++) offer_desc(make_desc(16384, 16384, 31, fmt_class_t'(3'(c))));
		offer_desc(make_desc(32767, 32767, 31, CLS_64BPP));
		offer_desc(make_desc(32767, 32767, 31, CLS_BLOCK16));
		offer_desc(make_desc(0, 0, 0, CLS_BLOCK8));
		offer_desc(make_desc(0, 0, 5, CLS_32BPP));
		offer_desc(make_desc(0, 7, 3, CLS_BLOCK16));
		offer_desc(make_desc(13, 0, 4, CLS_24BPP));
		offer_desc(make_desc(5, 3, 4, CLS_BLOCK8));
		offer_desc(make_desc(1, 1, 1, CLS_16BPP));
		offer_desc(make_desc(32767, 1, 31, CLS_BLOCK16));
		offer_desc(make_desc(1, 32767, 31, CLS_8BPP));
		offer_desc(make_desc(100, 60, 31, CLS_UNKNOWN));
		offer_desc(make_desc(0, 0, 0, CLS_UNKNOWN));
		offer_desc(make_desc(300, 200, 0, CLS_64BPP));
		offer_desc(make_desc(16384, 8192, 15, CLS_64BPP));

		repeat (PHASE_ITEMS) offer_desc(random_desc());

		// hold the receiver off while descriptors keep coming, then drain
		hold_requests <= hold_requests + 1;
		tx_idle_pct = 0;
		repeat (12) offer_desc(random_desc());
		desc_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		tx_idle_pct = 88;
		rx_idle_pct <= 35;
		repeat (PHASE_ITEMS) offer_desc(random_desc());

		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		repeat (PHASE_ITEMS) offer_desc(random_desc());
		desc_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: texture_surface_size_calc.f
hw/rtl/tssc_pkg.sv
hw/rtl/tssc_front.sv
hw/rtl/tssc_queue.sv
hw/rtl/tssc_back.sv
hw/rtl/texture_surface_size_calc.sv
test/surface_size_checker.sv
test/tb_texture_surface_size_calc.sv
